### rtl/core/tmt_pkg.sv
package tmt_pkg;

   // field widths of the request and response channels
   localparam int OP_W      = 3;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int COL_IN_W  = 7;
   localparam int ROW_IN_W  = 5;
   localparam int POS_OUT_W = 11;
   localparam int CELL_W    = CHAR_W + ATTR_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_PRINT  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET    = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [CHAR_W-1:0] NULL_CODE    = 8'h00;
   localparam logic [ATTR_W-1:0] STYLE_RESET  = 8'd15;

endpackage

### rtl/core/text_mode_terminal_writer_core.sv
// Character-cell text screen with a cursor, COLS x ROWS cells of char + attribute.
// Request channel (req_valid / req_stall) carries one operation: print, set cursor,
// clear screen, delete last, read cell. Every request gives exactly one response
// on rsp_valid / rsp_stall with the cursor after the operation, the cell read and
// a scroll flag. csr_wr_en / csr_wr_data load the default attribute at any idle time.
// One request at a time (req_stall is high while an operation is in work):
//   print without scroll, set cursor, unused codes: straight to the response state
//   read cell, delete last: a memory read first (S_RDATA / S_DEL_WR), skipped for an
//   off-screen cell or a cursor at the origin
//   clear screen: one cell written per cycle (S_CLEAR), then the response
//   print or newline that scrolls: a read counter runs one row ahead of a write
//   counter over the screen memory, reading row r+1 while writing row r, then
//   blanks the bottom row
// The screen memory takes one write and one registered read per cycle.
// After reset the block runs a clearing pass over all COLS*ROWS cells
// with req_stall high; the cursor is at the origin and the attribute is 15.
// A finished response sits in an output register; a request may be taken while it
// waits, but the next response is held in the block until rsp_stall drops.
module text_mode_terminal_writer_core #(
   parameter int unsigned COLS = 80,
   parameter int unsigned ROWS = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tmt_pkg::OP_W-1:0]            req_operation,
   input  logic [tmt_pkg::CHAR_W-1:0]          req_char_code,
   input  logic [tmt_pkg::ATTR_W-1:0]          req_attribute,
   input  logic [tmt_pkg::COL_IN_W-1:0]        req_column,
   input  logic [tmt_pkg::ROW_IN_W-1:0]        req_row_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tmt_pkg::POS_OUT_W-1:0]       rsp_cursor_pos,
   output logic [tmt_pkg::CHAR_W-1:0]          rsp_cell_char,
   output logic [tmt_pkg::ATTR_W-1:0]          rsp_cell_attr,
   output logic                                rsp_scrolled,
   input  logic                                csr_wr_en,
   input  logic [tmt_pkg::ATTR_W-1:0]          csr_wr_data
);

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);
   localparam int EXT_W = (AW > tmt_pkg::POS_OUT_W) ? AW : tmt_pkg::POS_OUT_W;

   localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_ROW_0 = AW'(CELLS - COLS);
   localparam logic [AW-1:0] COLS_A     = AW'(COLS);
   localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);
   localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_RDATA, S_DEL_WR, S_SCROLL, S_BLANK, S_CLEAR, S_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0] cur_pos_ff, cur_pos_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic          pend_ff, pend_in;
   logic [tmt_pkg::ATTR_W-1:0] style_ff, style_in;

   logic [tmt_pkg::CHAR_W-1:0] res_char_ff, res_char_in;
   logic [tmt_pkg::ATTR_W-1:0] res_attr_ff, res_attr_in;
   logic                       res_scr_ff, res_scr_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tmt_pkg::POS_OUT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [tmt_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic [tmt_pkg::ATTR_W-1:0]    rsp_attr_ff, rsp_attr_in;
   logic                          rsp_scr_ff, rsp_scr_in;

   // screen memory: one write port, one registered read port
   logic [tmt_pkg::CELL_W-1:0] screen_mem_ff [CELLS];
   logic [tmt_pkg::CELL_W-1:0] mem_rdata_ff;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [AW-1:0]              mem_raddr;
   logic [tmt_pkg::CELL_W-1:0] mem_wdata;

   logic [8:0]                 col_x;
   logic [7:0]                 row_x;
   logic                       col_ok;
   logic                       row_ok;
   logic [CW-1:0]              col_sel;
   logic [RW-1:0]              row_sel;
   logic [AW-1:0]              sel_addr;
   logic [AW-1:0]              nl_pos;
   logic [tmt_pkg::ATTR_W-1:0] attr_sel;
   logic [EXT_W-1:0]           pos_ext;
   logic                       req_xfer;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign col_x    = 9'(req_column);
   assign row_x    = 8'(req_row_index);
   assign col_ok   = col_x < 9'(COLS);
   assign row_ok   = row_x < 8'(ROWS);
   assign col_sel  = col_ok ? CW'(req_column) : LAST_COL;
   assign row_sel  = row_ok ? RW'(req_row_index) : LAST_ROW;
   assign sel_addr = AW'(row_sel) * COLS_A + AW'(col_sel);
   assign nl_pos   = cur_pos_ff - AW'(cur_col_ff) + COLS_A;
   assign attr_sel = (req_attribute == '0) ? style_ff : req_attribute;
   assign pos_ext  = EXT_W'(cur_pos_ff);

   always_comb begin
      state_in     = state_ff;
      cur_pos_in   = cur_pos_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      sweep_in     = sweep_ff;
      dst_in       = dst_ff;
      pend_in      = pend_ff;
      style_in     = csr_wr_en ? csr_wr_data : style_ff;
      res_char_in  = res_char_ff;
      res_attr_in  = res_attr_ff;
      res_scr_in   = res_scr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pos_in   = rsp_pos_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_scr_in   = rsp_scr_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_pos_ff;
      mem_wdata    = '0;
      mem_raddr    = sweep_ff;

      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               res_char_in = '0;
               res_attr_in = '0;
               res_scr_in  = 1'b0;
               state_in    = S_RESP;
               case (req_operation)
                  tmt_pkg::OP_PRINT: begin
                     if (req_char_code != tmt_pkg::NEWLINE_CODE) begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_pos_ff;
                        mem_wdata = {attr_sel, req_char_code};
                     end
                     if (req_char_code != tmt_pkg::NEWLINE_CODE && cur_col_ff != LAST_COL)
                     begin
                        cur_col_in = cur_col_ff + 1'b1;
                        cur_pos_in = cur_pos_ff + 1'b1;
                     end else if (cur_row_ff != LAST_ROW) begin
                        cur_col_in = '0;
                        cur_row_in = cur_row_ff + 1'b1;
                        cur_pos_in = nl_pos;
                     end else begin
                        // past the last cell: scroll, cursor to start of bottom row
                        cur_col_in = '0;
                        cur_row_in = LAST_ROW;
                        cur_pos_in = LAST_ROW_0;
                        res_scr_in = 1'b1;
                        sweep_in   = COLS_A;
                        dst_in     = '0;
                        pend_in    = 1'b0;
                        state_in   = S_SCROLL;
                     end
                  end
                  tmt_pkg::OP_SET: begin
                     cur_col_in = col_sel;
                     cur_row_in = row_sel;
                     cur_pos_in = sel_addr;
                  end
                  tmt_pkg::OP_CLEAR: begin
                     cur_col_in = '0;
                     cur_row_in = '0;
                     cur_pos_in = '0;
                     sweep_in   = '0;
                     state_in   = S_CLEAR;
                  end
                  tmt_pkg::OP_DELETE: begin
                     if (cur_pos_ff != '0) begin
                        cur_pos_in = cur_pos_ff - 1'b1;
                        mem_raddr  = cur_pos_ff - 1'b1;
                        if (cur_col_ff == '0) begin
                           cur_col_in = LAST_COL;
                           cur_row_in = cur_row_ff - 1'b1;
                        end else begin
                           cur_col_in = cur_col_ff - 1'b1;
                        end
                        state_in = S_DEL_WR;
                     end
                  end
                  tmt_pkg::OP_READ: begin
                     if (col_ok && row_ok) begin
                        mem_raddr = sel_addr;
                        state_in  = S_RDATA;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RDATA: begin
            res_char_in = mem_rdata_ff[tmt_pkg::CHAR_W-1:0];
            res_attr_in = mem_rdata_ff[tmt_pkg::CELL_W-1:tmt_pkg::CHAR_W];
            state_in    = S_RESP;
         end
         S_DEL_WR: begin
            // keep the attribute, drop the character
            mem_we    = 1'b1;
            mem_waddr = cur_pos_ff;
            mem_wdata = {mem_rdata_ff[tmt_pkg::CELL_W-1:tmt_pkg::CHAR_W], tmt_pkg::NULL_CODE};
            state_in  = S_RESP;
         end
         S_SCROLL: begin
            // read one row ahead, write the cell read last cycle
            mem_raddr = sweep_ff;
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff;
               mem_wdata = mem_rdata_ff;
               dst_in    = dst_ff + 1'b1;
            end
            pend_in = 1'b1;
            if (sweep_ff == LAST_CELL) begin
               state_in = S_BLANK;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
            mem_wdata = pend_ff ? mem_rdata_ff : {style_ff, tmt_pkg::NULL_CODE};
            pend_in   = 1'b0;
            if (dst_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = S_RESP;
            end else begin
               dst_in = dst_ff + 1'b1;
            end
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = {style_ff, tmt_pkg::SPACE_CODE};
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = S_RESP;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ext[tmt_pkg::POS_OUT_W-1:0];
               rsp_char_in  = res_char_ff;
               rsp_attr_in  = res_attr_ff;
               rsp_scr_in   = res_scr_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cur_pos_ff   <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         sweep_ff     <= '0;
         dst_ff       <= '0;
         pend_ff      <= 1'b0;
         style_ff     <= tmt_pkg::STYLE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_pos_ff   <= cur_pos_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         sweep_ff     <= sweep_in;
         dst_ff       <= dst_in;
         pend_ff      <= pend_in;
         style_ff     <= style_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_char_ff <= res_char_in;
      res_attr_ff <= res_attr_in;
      res_scr_ff  <= res_scr_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem_ff[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= screen_mem_ff[mem_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_scrolled   = rsp_scr_ff;

   // linear cursor tracks row and column
   a_cursor_consistent: assert property (@(posedge clock) disable iff (reset)
      cur_pos_ff == AW'(cur_row_ff) * COLS_A + AW'(cur_col_ff))
      else $error("cursor index does not match row and column");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (cur_col_ff <= LAST_COL) && (cur_row_ff <= LAST_ROW))
      else $error("cursor outside the screen");

   // during the copy the write pointer trails the read pointer by one row plus one
   a_scroll_distance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL && pend_ff) |-> (sweep_ff == dst_ff + COLS_A + 1'b1))
      else $error("scroll read and write pointers out of step");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response loaded outside the response state");

endmodule
